/* sv/bev_pkg.sv */
// Package: shared constants for the button event generator.
`default_nettype none
package bev_pkg;

   localparam int NUM_BUTTONS_DEF = 7;

   localparam int KIND_W   = 2;
   localparam int BTN_W    = 3;
   localparam int TIME_W   = 32;
   localparam int SAMP_W   = 6;
   localparam int EVK_W    = 3;
   localparam int CFG_W    = 16;
   localparam int CSR_A_W  = 2;
   localparam int REQ_D_W  = 80;
   localparam int RSP_D_W  = 72;

   localparam logic [KIND_W-1:0] KIND_EDGE      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_IDLE_QRY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IDLE_RST  = 2'd3;

   localparam logic [EVK_W-1:0] EV_PRESS   = 3'd0;
   localparam logic [EVK_W-1:0] EV_RELEASE = 3'd1;
   localparam logic [EVK_W-1:0] EV_REPEAT  = 3'd2;
   localparam logic [EVK_W-1:0] EV_LONG    = 3'd3;
   localparam logic [EVK_W-1:0] EV_IDLE    = 3'd4;

   localparam logic [CSR_A_W-1:0] CSR_REPEAT_START    = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_REPEAT_INTERVAL = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_LONG_PRESS      = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_REPEAT_MASK     = 2'd3;

   localparam logic [CFG_W-1:0]  RST_REPEAT_START    = 16'd400;
   localparam logic [CFG_W-1:0]  RST_REPEAT_INTERVAL = 16'd150;
   localparam logic [CFG_W-1:0]  RST_LONG_PRESS      = 16'd1000;
   localparam logic [SAMP_W-1:0] RST_REPEAT_MASK     = 6'd3;

endpackage
`default_nettype wire

/* sv/button_event_generator.sv */
// Top level: button press, release, auto-repeat, long-press and idle event generator.
// Edge and idle query items pass through the execute and flush states; a tick walks the
// buttons one per cycle through one shared subtract/compare unit, unless an output stall
// holds the walk, then flushes its last result. One transaction at a time, also held by
// output stalls; req_tready is high only while idle.
// Reset: synchronous, active high; clears marks, activity time and results, loads defaults.
`default_nettype none
module button_event_generator import bev_pkg::*; #(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // button[2:0], pressed[3], edge_time_ms[35:4], now_ms[67:36], sampled_mask[73:68]
   input  wire logic [REQ_D_W-1:0]  req_tdata,
   // kind[1:0]
   input  wire logic [KIND_W-1:0]   req_tuser,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // event_button[2:0], event_time_ms[34:3], idle_ms[66:35]
   output logic [RSP_D_W-1:0]       rsp_tdata,
   // event_kind[2:0]
   output logic [EVK_W-1:0]         rsp_tuser,
   output logic                     rsp_tlast,
   input  wire logic                csr_we,
   input  wire logic [CSR_A_W-1:0]  csr_addr,
   input  wire logic [CFG_W-1:0]    csr_wdata
);

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam logic [IDX_W-1:0] POWER_IDX = IDX_W'(NUM_BUTTONS - 1);
   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_BUTTONS - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;

   logic [KIND_W-1:0]       kind_ff;
   logic [BTN_W-1:0]        btn_ff;
   logic                    pressed_ff;
   logic [TIME_W-1:0]       edge_ff, now_ff;
   logic [SAMP_W-1:0]       samp_ff;

   logic [CFG_W-1:0]        rep_start_ff, rep_int_ff, long_ff;
   logic [SAMP_W-1:0]       rep_mask_ff;

   logic [NUM_BUTTONS-1:0]  held_ff, held_in;
   logic [NUM_BUTTONS-1:0]  fired_ff, fired_in;
   logic [TIME_W-1:0]       act_ff, act_in;
   logic [TIME_W-1:0]       pst_ff [NUM_BUTTONS];
   logic [TIME_W-1:0]       lrt_ff [NUM_BUTTONS];

   logic                    pend_v_ff, pend_v_in;
   logic [EVK_W-1:0]        pend_k_ff, pend_k_in;
   logic [BTN_W-1:0]        pend_b_ff, pend_b_in;
   logic [TIME_W-1:0]       pend_t_ff, pend_t_in;
   logic [TIME_W-1:0]       pend_i_ff, pend_i_in;

   logic                    out_v_ff, out_v_in;
   logic                    out_l_ff, out_l_in;
   logic [EVK_W-1:0]        out_k_ff, out_k_in;
   logic [BTN_W-1:0]        out_b_ff, out_b_in;
   logic [TIME_W-1:0]       out_t_ff, out_t_in;
   logic [TIME_W-1:0]       out_i_ff, out_i_in;

   logic                    accept, out_free;
   logic [IDX_W-1:0]        cur;
   logic [NUM_BUTTONS-1:0]  samp_vec, rep_vec;
   logic                    cur_rep, cand, fire, stall;
   logic [TIME_W-1:0]       base, diff, thr;
   logic                    btn_ok;
   logic [IDX_W-1:0]        ebtn;
   logic                    pst_we, lrt_we;
   logic [IDX_W-1:0]        wr_idx;
   logic [TIME_W-1:0]       wr_val;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !out_v_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         samp_vec[i] = (i < SAMP_W) && (i != NUM_BUTTONS - 1) && samp_ff[i % SAMP_W];
         rep_vec[i]  = (i < SAMP_W) && (i != NUM_BUTTONS - 1) && rep_mask_ff[i % SAMP_W];
      end
   end

   assign cur     = (cnt_ff == '0) ? POWER_IDX : cnt_ff - IDX_W'(1);
   assign cur_rep = (cnt_ff != '0) && rep_vec[cur];
   assign btn_ok  = ({2'b00, btn_ff} < 5'(NUM_BUTTONS));
   assign ebtn    = IDX_W'(btn_ff);

   // shared subtract/compare unit
   always_comb begin
      priority if (state_ff == S_EXEC) begin
         base = act_ff;
      end else if (cur_rep) begin
         base = lrt_ff[cur];
      end else begin
         base = pst_ff[cur];
      end
      if (cur_rep) begin
         thr = (lrt_ff[cur] == pst_ff[cur]) ? TIME_W'(rep_start_ff) : TIME_W'(rep_int_ff);
      end else begin
         thr = TIME_W'(long_ff);
      end
   end
   assign diff = now_ff - base;

   always_comb begin
      if (cnt_ff == '0) begin
         cand = held_ff[cur] && !fired_ff[cur];
      end else if (cur_rep) begin
         cand = held_ff[cur] && samp_vec[cur];
      end else begin
         cand = held_ff[cur] && samp_vec[cur] && !fired_ff[cur];
      end
   end
   assign fire  = (state_ff == S_WALK) && cand && (diff >= thr);
   assign stall = fire && pend_v_ff && !out_free;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      held_in   = held_ff;
      fired_in  = fired_ff;
      act_in    = act_ff;
      pend_v_in = pend_v_ff;
      pend_k_in = pend_k_ff;
      pend_b_in = pend_b_ff;
      pend_t_in = pend_t_ff;
      pend_i_in = pend_i_ff;
      out_v_in  = out_v_ff && !rsp_tready;
      out_l_in  = out_l_ff;
      out_k_in  = out_k_ff;
      out_b_in  = out_b_ff;
      out_t_in  = out_t_ff;
      out_i_in  = out_i_ff;
      pst_we    = 1'b0;
      lrt_we    = 1'b0;
      wr_idx    = cur;
      wr_val    = now_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = (req_tuser == KIND_TICK) ? S_WALK : S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FLUSH;
            unique case (kind_ff)
               KIND_EDGE: begin
                  if (btn_ok && (pressed_ff != held_ff[ebtn])) begin
                     act_in    = now_ff;
                     held_in[ebtn] = pressed_ff;
                     pend_v_in = 1'b1;
                     pend_b_in = btn_ff;
                     pend_t_in = edge_ff;
                     pend_i_in = '0;
                     if (pressed_ff) begin
                        fired_in[ebtn] = 1'b0;
                        pst_we    = 1'b1;
                        lrt_we    = 1'b1;
                        wr_idx    = ebtn;
                        wr_val    = edge_ff;
                        pend_k_in = EV_PRESS;
                     end else begin
                        pend_k_in = EV_RELEASE;
                     end
                  end
               end
               KIND_IDLE_QRY: begin
                  pend_v_in = 1'b1;
                  pend_k_in = EV_IDLE;
                  pend_b_in = '0;
                  pend_t_in = now_ff;
                  pend_i_in = diff;
               end
               KIND_IDLE_RST: begin
                  act_in = now_ff;
               end
               default: begin
               end
            endcase
         end
         S_WALK: begin
            if (!stall) begin
               if (fire) begin
                  if (pend_v_ff) begin
                     out_v_in = 1'b1;
                     out_l_in = 1'b0;
                     out_k_in = pend_k_ff;
                     out_b_in = pend_b_ff;
                     out_t_in = pend_t_ff;
                     out_i_in = pend_i_ff;
                  end
                  pend_v_in = 1'b1;
                  pend_b_in = BTN_W'(cur);
                  pend_t_in = now_ff;
                  pend_i_in = '0;
                  if (cur_rep) begin
                     lrt_we    = 1'b1;
                     act_in    = now_ff;
                     pend_k_in = EV_REPEAT;
                  end else begin
                     fired_in[cur] = 1'b1;
                     pend_k_in = EV_LONG;
                  end
               end
               if (cnt_ff == LAST_STEP) begin
                  state_in = S_FLUSH;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end
         end
         S_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_v_in  = 1'b1;
               out_l_in  = 1'b1;
               out_k_in  = pend_k_ff;
               out_b_in  = pend_b_ff;
               out_t_in  = pend_t_ff;
               out_i_in  = pend_i_ff;
               pend_v_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         held_ff      <= '0;
         fired_ff     <= '0;
         act_ff       <= '0;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
         rep_start_ff <= RST_REPEAT_START;
         rep_int_ff   <= RST_REPEAT_INTERVAL;
         long_ff      <= RST_LONG_PRESS;
         rep_mask_ff  <= RST_REPEAT_MASK;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         held_ff   <= held_in;
         fired_ff  <= fired_in;
         act_ff    <= act_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_REPEAT_START:    rep_start_ff <= csr_wdata;
               CSR_REPEAT_INTERVAL: rep_int_ff   <= csr_wdata;
               CSR_LONG_PRESS:      long_ff      <= csr_wdata;
               CSR_REPEAT_MASK:     rep_mask_ff  <= csr_wdata[SAMP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_tuser;
         btn_ff     <= req_tdata[2:0];
         pressed_ff <= req_tdata[3];
         edge_ff    <= req_tdata[35:4];
         now_ff     <= req_tdata[67:36];
         samp_ff    <= req_tdata[73:68];
      end
      if (pst_we) begin
         pst_ff[wr_idx] <= wr_val;
      end
      if (lrt_we) begin
         lrt_ff[wr_idx] <= wr_val;
      end
      pend_k_ff <= pend_k_in;
      pend_b_ff <= pend_b_in;
      pend_t_ff <= pend_t_in;
      pend_i_ff <= pend_i_in;
      out_l_ff  <= out_l_in;
      out_k_ff  <= out_k_in;
      out_b_ff  <= out_b_in;
      out_t_ff  <= out_t_in;
      out_i_ff  <= out_i_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_l_ff;
   assign rsp_tuser  = out_k_ff;
   assign rsp_tdata  = {{(RSP_D_W - BTN_W - 2 * TIME_W){1'b0}}, out_i_ff, out_t_ff, out_b_ff};

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_v_ff)
      else $error("pending result left while idle");

   a_walk_ends_in_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && cnt_ff == LAST_STEP && !stall) |=> (state_ff == S_FLUSH))
      else $error("button walk did not end in flush");

   a_long_marks_button: assert property (@(posedge clock) disable iff (reset)
      (fire && !stall && !cur_rep) |=> fired_ff[$past(cur)])
      else $error("long press not recorded");

   a_last_only_on_flush: assert property (@(posedge clock) disable iff (reset)
      (out_v_in && !(out_v_ff && !rsp_tready) && out_l_in) |-> (state_ff == S_FLUSH))
      else $error("final result issued outside flush");

endmodule
`default_nettype wire
